// ===== sv/ram_io_timer_device_unit_macros.svh =====
// assertion macros shared by the ram, port and timer device modules
`ifndef RAM_IO_TIMER_DEVICE_UNIT_MACROS_SVH
`define RAM_IO_TIMER_DEVICE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define RAMIO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define RAMIO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ramio_pkg.sv =====
// shared types, codes and constants of the ram, port and timer device
package ramio_pkg;

   // default ram depth in bytes
   localparam int RAM_DEPTH_DEF = 256;

   // action codes of a request word
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // register map after folding
   localparam logic [15:0] ADDR_PORTA     = 16'h0280;
   localparam logic [15:0] ADDR_PORTA_DIR = 16'h0281;
   localparam logic [15:0] ADDR_PORTB     = 16'h0282;
   localparam logic [15:0] ADDR_PORTB_DIR = 16'h0283;
   localparam logic [15:0] ADDR_TCOUNT    = 16'h0284;
   localparam logic [15:0] ADDR_T1        = 16'h0294;
   localparam logic [15:0] ADDR_T8        = 16'h0295;
   localparam logic [15:0] ADDR_T64       = 16'h0296;
   localparam logic [15:0] ADDR_T1024     = 16'h0297;

   // bit that selects folding to the low byte
   localparam int FOLD_BIT = 8;

   // port reset values
   localparam logic [7:0] PORT_A_RESET = 8'hFF;
   localparam logic [7:0] PORT_B_RESET = 8'h0B;

   // prescale mode codes
   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_DIV1    = 3'd1;
   localparam logic [2:0] MODE_DIV8    = 3'd2;
   localparam logic [2:0] MODE_DIV64   = 3'd3;
   localparam logic [2:0] MODE_DIV1024 = 3'd4;

   // timer control from the decoder
   typedef struct packed {
      logic       tick;
      logic       load;
      logic [2:0] mode;
      logic [7:0] value;
   } tmr_ctl_type;

   // prescale divisor of a mode code
   function automatic logic [10:0] divisor_of(input logic [2:0] mode);
      logic [10:0] div;
      case (mode)
         MODE_DIV1:    div = 11'd1;
         MODE_DIV8:    div = 11'd8;
         MODE_DIV64:   div = 11'd64;
         MODE_DIV1024: div = 11'd1024;
         default:      div = 11'd0;
      endcase
      return div;
   endfunction

endpackage

// ===== sv/ramio_if.sv =====
// request and response channel interfaces of the device

// request channel: tick, read or write
interface ramio_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output action, output address, output write_data,
                   input ready);
   modport sink (input valid, input action, input address, input write_data,
                 output ready);
endinterface

// response channel: read byte and error flag
interface ramio_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       access_error;

   modport source (output valid, output read_data, output access_error, input ready);
   modport sink (input valid, input read_data, input access_error, output ready);
endinterface

// ===== sv/ram_io_timer_device_unit.sv =====
// top level of the ram, port and timer device: decode, ram and response path
// a response word passes from stage one (with the ram read register) into the output register
// throughput: one request word per cycle while the response side takes words and no clearing pass runs
// the ram read port, a registered read, sets the two-stage response path
// reset: ports and timer take their reset values at once; the ram is then
// cleared one byte a cycle, index 0 up to RAM_DEPTH-1, with req_chan.ready low
`include "ram_io_timer_device_unit_macros.svh"

module ram_io_timer_device_unit #(
   parameter int RAM_DEPTH = ramio_pkg::RAM_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   ramio_req_if.sink           req_chan,
   ramio_rsp_if.source         rsp_chan
);

   localparam int AW = $clog2(RAM_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(RAM_DEPTH - 1);

   // ram storage
   logic [7:0] ram_mem [RAM_DEPTH];
   logic [7:0] rdata_ff;

   // clearing pass
   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_idx_ff, clear_idx_in;

   // port registers
   logic [7:0] pa_ff, pa_in;
   logic [7:0] pb_ff, pb_in;

   // decode
   logic [15:0]            folded;
   logic                   in_ram;
   logic [AW-1:0]          ram_idx;
   logic [7:0]             rd_val;
   logic                   from_ram;
   logic                   err;
   logic                   ram_we;
   logic                   pa_we;
   logic                   pb_we;
   ramio_pkg::tmr_ctl_type tctl;
   logic [7:0]             tcount;
   logic                   req_accept;

   // stage one and output register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_from_ram_ff;
   logic [7:0] s1_val_ff;
   logic       s1_err_ff;
   logic       s1_move;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_rd_ff;
   logic       out_err_ff;

   assign s1_move        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !clear_ff && (!s1_valid_ff || s1_move);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // address folding and ram range
   assign folded  = req_chan.address[ramio_pkg::FOLD_BIT]
                    ? {8'h00, req_chan.address[7:0]} : req_chan.address;
   assign in_ram  = folded < 16'(RAM_DEPTH);
   assign ram_idx = folded[AW-1:0];

   // request decode
   always_comb begin
      rd_val     = '0;
      from_ram   = 1'b0;
      err        = 1'b0;
      ram_we     = 1'b0;
      pa_we      = 1'b0;
      pb_we      = 1'b0;
      tctl.tick  = 1'b0;
      tctl.load  = 1'b0;
      tctl.mode  = ramio_pkg::MODE_NONE;
      tctl.value = req_chan.write_data;
      case (req_chan.action)
         ramio_pkg::ACT_TICK: begin
            tctl.tick = req_accept;
         end
         ramio_pkg::ACT_READ: begin
            case (folded)
               ramio_pkg::ADDR_PORTA:     rd_val = pa_ff;
               ramio_pkg::ADDR_PORTA_DIR: rd_val = '0;
               ramio_pkg::ADDR_PORTB:     rd_val = pb_ff;
               ramio_pkg::ADDR_PORTB_DIR: rd_val = '0;
               ramio_pkg::ADDR_TCOUNT:    rd_val = tcount;
               default: begin
                  from_ram = in_ram;
                  err      = !in_ram;
               end
            endcase
         end
         ramio_pkg::ACT_WRITE: begin
            case (folded)
               ramio_pkg::ADDR_PORTA:     pa_we = req_accept;
               ramio_pkg::ADDR_PORTB:     pb_we = req_accept;
               ramio_pkg::ADDR_PORTA_DIR: rd_val = '0;
               ramio_pkg::ADDR_PORTB_DIR: rd_val = '0;
               ramio_pkg::ADDR_T1: begin
                  tctl.load = req_accept;
                  tctl.mode = ramio_pkg::MODE_DIV1;
               end
               ramio_pkg::ADDR_T8: begin
                  tctl.load = req_accept;
                  tctl.mode = ramio_pkg::MODE_DIV8;
               end
               ramio_pkg::ADDR_T64: begin
                  tctl.load = req_accept;
                  tctl.mode = ramio_pkg::MODE_DIV64;
               end
               ramio_pkg::ADDR_T1024: begin
                  tctl.load = req_accept;
                  tctl.mode = ramio_pkg::MODE_DIV1024;
               end
               default: begin
                  ram_we = req_accept && in_ram;
                  err    = !in_ram;
               end
            endcase
         end
         default: begin
            rd_val = '0;
         end
      endcase
   end

   // timer
   ramio_timer u_timer (
      .clock (clock),
      .reset (reset),
      .ctl   (tctl),
      .count (tcount)
   );

   // ram: clearing pass or write, read on accepted ram read
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         ram_mem[clear_idx_ff] <= '0;
      end else if (ram_we) begin
         ram_mem[ram_idx] <= req_chan.write_data;
      end
      if (req_accept && from_ram) begin
         rdata_ff <= ram_mem[ram_idx];
      end
   end

   // clearing pass control
   always_comb begin
      clear_in     = clear_ff;
      clear_idx_in = clear_idx_ff;
      if (clear_ff) begin
         clear_idx_in = clear_idx_ff + AW'(1);
         if (clear_idx_ff == LAST_IDX) begin
            clear_in = 1'b0;
         end
      end
   end

   // port registers next value
   assign pa_in = pa_we ? req_chan.write_data : pa_ff;
   assign pb_in = pb_we ? req_chan.write_data : pb_ff;

   // response valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
         pa_ff        <= ramio_pkg::PORT_A_RESET;
         pb_ff        <= ramio_pkg::PORT_B_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_idx_ff <= clear_idx_in;
         pa_ff        <= pa_in;
         pb_ff        <= pb_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_from_ram_ff <= from_ram;
         s1_val_ff      <= rd_val;
         s1_err_ff      <= err;
      end
      if (s1_move) begin
         out_rd_ff  <= s1_from_ram_ff ? rdata_ff : s1_val_ff;
         out_err_ff <= s1_err_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.read_data    = out_rd_ff;
   assign rsp_chan.access_error = out_err_ff;

   `RAMIO_ASSERT_NEXT(a_clear_ends, clear_ff && clear_idx_ff == LAST_IDX, !clear_ff, "clearing pass overran")
   `RAMIO_ASSERT_NEXT(a_accept_s1, req_accept, s1_valid_ff, "accepted word lost before stage one")
   `RAMIO_ASSERT_NEXT(a_stall_hold, s1_valid_ff && !s1_move, s1_valid_ff && $stable(rdata_ff), "ram data changed under a stalled word")

endmodule

// ===== sv/ramio_timer.sv =====
// interval timer with prescaler, load and tick handling
`include "ram_io_timer_device_unit_macros.svh"

module ramio_timer (
   input  logic                   clock,
   input  logic                   reset,
   input  ramio_pkg::tmr_ctl_type ctl,
   output logic [7:0]             count
);

   logic [2:0]  mode_ff, mode_in;
   logic [10:0] pc_ff, pc_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        exp_ff, exp_in;
   logic [10:0] pc_dec;
   logic [7:0]  cnt_dec;
   logic        prescaled;

   assign pc_dec    = pc_ff - 11'd1;
   assign cnt_dec   = cnt_ff - 8'd1;
   assign prescaled = (mode_ff != ramio_pkg::MODE_NONE) && (mode_ff <= ramio_pkg::MODE_DIV1024);

   // next timer state
   always_comb begin
      mode_in = mode_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      exp_in  = exp_ff;
      if (ctl.load) begin
         mode_in = ctl.mode;
         pc_in   = ramio_pkg::divisor_of(ctl.mode);
         cnt_in  = ctl.value;
         exp_in  = 1'b0;
      end else if (ctl.tick) begin
         if (mode_ff == ramio_pkg::MODE_NONE) begin
            // free run after expiry or reset
            cnt_in = cnt_dec;
         end else if (prescaled) begin
            pc_in = pc_dec;
            if (pc_dec == 11'd0) begin
               pc_in  = ramio_pkg::divisor_of(mode_ff);
               cnt_in = cnt_dec;
               if (exp_ff) begin
                  mode_in = ramio_pkg::MODE_NONE;
               end
            end
            if (cnt_in == 8'd0) begin
               exp_in = 1'b1;
            end
         end
      end
   end

   // timer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ramio_pkg::MODE_NONE;
         pc_ff   <= '0;
         cnt_ff  <= '0;
         exp_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
         exp_ff  <= exp_in;
      end
   end

   assign count = cnt_ff;

   `RAMIO_ASSERT_NOW(a_pc_nonzero, prescaled, pc_ff != 11'd0, "prescaler idle in prescaled mode")
   `RAMIO_ASSERT_NEXT(a_load_clears, ctl.load, !exp_ff, "expired flag survived a load")
   `RAMIO_ASSERT_NEXT(a_free_run, ctl.tick && !ctl.load && prescaled && exp_ff && pc_ff == 11'd1, mode_ff == ramio_pkg::MODE_NONE, "timer did not enter free run")

endmodule

// ===== tb/ram_io_timer_device_unit_tb.sv =====
// testbench of the ram, port and timer device: directed table, random traffic, self-checking
module ram_io_timer_device_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ramio_pkg::*;

   localparam int RAM_DEPTH      = RAM_DEPTH_DEF;
   localparam int HALF_PERIOD    = 4;
   localparam int RANDOM_WORDS   = 1050;
   localparam int PHASE_WORDS    = RANDOM_WORDS / 4;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DIRECTED_ROWS  = 25;

   // action code the block must ignore
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
   } bus_word_t;

   typedef struct packed {
      logic [7:0] read_data;
      logic       access_error;
   } bus_result_t;

   // one row of the directed table, with an optional typed-in result
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        golden_on;
      logic [7:0]  golden_rd;
      logic        golden_err;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;
   logic sink_ready = 1'b1;

   ramio_req_if req_chan ();
   ramio_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   ram_io_timer_device_unit #(
      .RAM_DEPTH(RAM_DEPTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // shadow copy of the device state
   logic [7:0]  ram_image [RAM_DEPTH];
   logic [7:0]  port_a_image;
   logic [7:0]  port_b_image;
   logic [2:0]  pre_mode;
   logic [10:0] pre_count;
   logic [7:0]  tmr_count;
   logic        tmr_fired;

   bus_result_t pending_results [$];
   logic        golden_pending = 1'b0;
   bus_result_t golden_value = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int fire_events = 0;
   int quiet_cycles = 0;

   stim_row_t directed_rows [DIRECTED_ROWS];

   // clock
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // response side back-pressure
   always @(negedge clock) begin
      sink_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [10:0] prescale_divisor(input logic [2:0] mode);
      case (mode)
         MODE_DIV1:    return 11'd1;
         MODE_DIV8:    return 11'd8;
         MODE_DIV64:   return 11'd64;
         MODE_DIV1024: return 11'd1024;
         default:      return 11'd0;
      endcase
   endfunction

   // applies one word to the shadow state and returns the response it causes
   function automatic bus_result_t predict_bus_access(input bus_word_t w);
      bus_result_t res;
      logic [15:0] addr;
      res = '0;
      addr = w.address;
      if (addr[FOLD_BIT])
         addr = {8'h00, addr[7:0]};
      case (w.action)
         ACT_TICK: begin
            if (pre_mode == MODE_NONE) begin
               tmr_count = tmr_count - 8'd1;
            end else if (pre_mode <= MODE_DIV1024) begin
               pre_count = pre_count - 11'd1;
               if (pre_count == 11'd0) begin
                  pre_count = prescale_divisor(pre_mode);
                  tmr_count = tmr_count - 8'd1;
                  if (tmr_fired)
                     pre_mode = MODE_NONE;
               end
               if (tmr_count == 8'd0) begin
                  if (!tmr_fired)
                     fire_events++;
                  tmr_fired = 1'b1;
               end
            end
         end
         ACT_READ: begin
            case (addr)
               ADDR_PORTA:     res.read_data = port_a_image;
               ADDR_PORTA_DIR: res.read_data = 8'h00;
               ADDR_PORTB:     res.read_data = port_b_image;
               ADDR_PORTB_DIR: res.read_data = 8'h00;
               ADDR_TCOUNT:    res.read_data = tmr_count;
               default: begin
                  if (addr < RAM_DEPTH)
                     res.read_data = ram_image[addr];
                  else
                     res.access_error = 1'b1;
               end
            endcase
         end
         ACT_WRITE: begin
            case (addr)
               ADDR_PORTA: port_a_image = w.write_data;
               ADDR_PORTB: port_b_image = w.write_data;
               ADDR_PORTA_DIR, ADDR_PORTB_DIR: ;
               ADDR_T1, ADDR_T8, ADDR_T64, ADDR_T1024: begin
                  case (addr)
                     ADDR_T1:  pre_mode = MODE_DIV1;
                     ADDR_T8:  pre_mode = MODE_DIV8;
                     ADDR_T64: pre_mode = MODE_DIV64;
                     default:  pre_mode = MODE_DIV1024;
                  endcase
                  pre_count = prescale_divisor(pre_mode);
                  tmr_count = w.write_data;
                  tmr_fired = 1'b0;
               end
               default: begin
                  if (addr < RAM_DEPTH)
                     ram_image[addr] = w.write_data;
                  else
                     res.access_error = 1'b1;
               end
            endcase
         end
         default: ;
      endcase
      return res;
   endfunction

   // random word, weighted toward timer runs and ram traffic
   function automatic bus_word_t random_word();
      bus_word_t w;
      int pick;
      int sel;
      w.action = ACT_TICK;
      w.address = 16'($urandom_range(16'hFFFF));
      w.write_data = 8'($urandom_range(8'hFF));
      pick = $urandom_range(99);
      if (pick < 40) begin
         w.action = ACT_TICK;
      end else if (pick < 55) begin
         w.action = ACT_READ;
         w.address = ADDR_TCOUNT;
      end else if (pick < 60) begin
         // timer load, mostly short counts so the timer runs out
         w.action = ACT_WRITE;
         sel = $urandom_range(99);
         w.address = (sel < 45) ? ADDR_T1 : (sel < 85) ? ADDR_T8 :
                     (sel < 97) ? ADDR_T64 : ADDR_T1024;
         if ($urandom_range(3) != 0)
            w.write_data = 8'($urandom_range(12));
      end else if (pick < 75) begin
         // ram access, plain or folded, often in the first 16 bytes
         w.action = $urandom_range(1) ? ACT_WRITE : ACT_READ;
         if ($urandom_range(1))
            w.address[7:0] = 8'($urandom_range(15));
         if ($urandom_range(1))
            w.address[FOLD_BIT] = 1'b1;
         else
            w.address[15:8] = 8'h00;
      end else if (pick < 85) begin
         w.action = $urandom_range(1) ? ACT_WRITE : ACT_READ;
         w.address = ADDR_PORTA + 16'($urandom_range(3));
      end else if (pick < 95) begin
         w.action = $urandom_range(1) ? ACT_WRITE : ACT_READ;
      end else begin
         // unused action, reads of write-only timer regs, writes to the count
         sel = $urandom_range(2);
         if (sel == 0) begin
            w.action = ACT_UNUSED;
         end else if (sel == 1) begin
            w.action = ACT_READ;
            w.address = ADDR_T1 + 16'($urandom_range(3));
         end else begin
            w.action = ACT_WRITE;
            w.address = ADDR_TCOUNT;
         end
      end
      return w;
   endfunction

   // drive one request word and hold it until the handshake
   task automatic send_word(input bus_word_t w, input logic golden_on,
                            input bus_result_t golden);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= w.action;
      req_chan.address    <= w.address;
      req_chan.write_data <= w.write_data;
      golden_pending      <= golden_on;
      golden_value        <= golden;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready))
         @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // response check, prediction of accepted words, watchdog
   always @(posedge clock) begin
      bus_result_t exp_res;
      bus_result_t pred;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response with nothing expected, actual rd %02h err %0b",
                        $time, rsp_chan.read_data, rsp_chan.access_error);
               mismatch_count++;
            end else begin
               exp_res = pending_results.pop_front();
               results_checked++;
               if (rsp_chan.read_data !== exp_res.read_data) begin
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, exp_res.read_data, rsp_chan.read_data);
                  mismatch_count++;
               end
               if (rsp_chan.access_error !== exp_res.access_error) begin
                  $display("%0t: access_error mismatch, expected %0b, actual %0b",
                           $time, exp_res.access_error, rsp_chan.access_error);
                  mismatch_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            pred = predict_bus_access({req_chan.action, req_chan.address,
                                       req_chan.write_data});
            pending_results.push_back(golden_pending ? golden_value : pred);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.action     = ACT_TICK;
      req_chan.address    = 16'h0000;
      req_chan.write_data = 8'h00;

      for (int i = 0; i < RAM_DEPTH; i++)
         ram_image[i] = 8'h00;
      port_a_image = PORT_A_RESET;
      port_b_image = PORT_B_RESET;
      pre_mode  = MODE_NONE;
      pre_count = 11'd0;
      tmr_count = 8'd0;
      tmr_fired = 1'b0;

      // directed rows: reset values, folding, errors, every timer prescale
      directed_rows = '{
         '{ACT_READ,   ADDR_PORTA,     8'h00, 1'b1, PORT_A_RESET, 1'b0},
         '{ACT_READ,   ADDR_PORTB,     8'h00, 1'b1, PORT_B_RESET, 1'b0},
         '{ACT_READ,   ADDR_PORTA_DIR, 8'h00, 1'b1, 8'h00, 1'b0},
         '{ACT_READ,   ADDR_PORTB_DIR, 8'h00, 1'b1, 8'h00, 1'b0},
         '{ACT_READ,   ADDR_TCOUNT,    8'h00, 1'b1, 8'h00, 1'b0},
         '{ACT_READ,   16'h0000,       8'h00, 1'b1, 8'h00, 1'b0},
         '{ACT_READ,   16'hFFFF,       8'h00, 1'b1, 8'h00, 1'b0},
         '{ACT_TICK,   16'hFFFF,       8'hFF, 1'b1, 8'h00, 1'b0},
         '{ACT_READ,   ADDR_TCOUNT,    8'h00, 1'b1, 8'hFF, 1'b0},
         '{ACT_WRITE,  16'h0000,       8'hFF, 1'b1, 8'h00, 1'b0},
         '{ACT_WRITE,  16'h01FF,       8'hA5, 1'b1, 8'h00, 1'b0},
         '{ACT_READ,   16'h0000,       8'h00, 1'b0, 8'h00, 1'b0},
         '{ACT_READ,   16'h00FF,       8'h00, 1'b0, 8'h00, 1'b0},
         '{ACT_WRITE,  ADDR_PORTA,     8'h00, 1'b0, 8'h00, 1'b0},
         '{ACT_WRITE,  ADDR_PORTB_DIR, 8'h55, 1'b0, 8'h00, 1'b0},
         '{ACT_READ,   ADDR_PORTA,     8'h00, 1'b0, 8'h00, 1'b0},
         '{ACT_READ,   16'hFEFF,       8'h00, 1'b1, 8'h00, 1'b1},
         '{ACT_WRITE,  16'h0200,       8'h12, 1'b1, 8'h00, 1'b1},
         '{ACT_READ,   ADDR_T1,        8'h00, 1'b1, 8'h00, 1'b1},
         '{ACT_WRITE,  ADDR_TCOUNT,    8'h33, 1'b1, 8'h00, 1'b1},
         '{ACT_UNUSED, 16'hFFFF,       8'hFF, 1'b1, 8'h00, 1'b0},
         '{ACT_WRITE,  ADDR_T8,        8'h01, 1'b0, 8'h00, 1'b0},
         '{ACT_WRITE,  ADDR_T64,       8'hFF, 1'b0, 8'h00, 1'b0},
         '{ACT_WRITE,  ADDR_T1024,     8'h80, 1'b0, 8'h00, 1'b0},
         '{ACT_WRITE,  ADDR_T1,        8'h01, 1'b0, 8'h00, 1'b0}
      };

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word({directed_rows[i].action, directed_rows[i].address,
                    directed_rows[i].write_data},
                   directed_rows[i].golden_on,
                   {directed_rows[i].golden_rd, directed_rows[i].golden_err});

      // random traffic in four idling phases
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % PHASE_WORDS == 0) begin
            case (i / PHASE_WORDS)
               0:       begin idle_pct = 0;  stall_pct = 0;  end
               1:       begin idle_pct = 70; stall_pct = 0;  end
               2:       begin idle_pct = 0;  stall_pct = 70; end
               default: begin idle_pct = 17; stall_pct = 17; end
            endcase
         end
         send_word(random_word(), 1'b0, '0);
      end
      req_chan.valid <= 1'b0;

      // drain
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words (ticks, ram, ports, timer loads, errors), %0d responses",
               words_sent, results_checked);
      $display("timer ran out %0d times, %0d mismatches", fire_events, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== ram_io_timer_device_unit.f =====
+incdir+sv
sv/ramio_pkg.sv
sv/ramio_if.sv
sv/ramio_timer.sv
sv/ram_io_timer_device_unit.sv
tb/ram_io_timer_device_unit_tb.sv
